### rtl/core/pceq_pkg.sv
// shared types and constants of the pulse cadence event qualifier
`default_nettype none
package pceq_pkg;
   localparam int TIME_BITS = 32;
   localparam int COUNT_BITS = 16;
   localparam int CAD_BITS = 24;
   localparam int CONF_BITS = 11;
   localparam int LEVEL_REG_BITS = 56;
   localparam int CAD_REG_BITS = 40;
   localparam int CSR_INDEX_BITS = 3;
   localparam int NUM_REGS = 6;
   localparam int RATE_BITS = 20;
   localparam int DIV_NUM_BITS = 36;
   localparam logic [19:0] MHZ_PER_HZ = 20'd1000000;
   localparam logic [CAD_BITS-1:0] CAD_SAT = {CAD_BITS{1'b1}};
   localparam logic [CONF_BITS-1:0] CONF_ONE = 11'd1024;

   typedef enum logic [1:0] {
      VERDICT_QUALIFIED = 2'd0,
      VERDICT_LIMIT     = 2'd1,
      VERDICT_FEW_RISES = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_CHECK,
      BK_DIV_CAD,
      BK_DIV_CONF,
      BK_DONE
   } back_state_type;

   // closed burst handed from front to back
   typedef struct packed {
      logic [1:0]            channel;
      logic [COUNT_BITS-1:0] count;
      logic [TIME_BITS-1:0]  span;
      logic [TIME_BITS-1:0]  duration;
      logic [TIME_BITS-1:0]  now;
      logic [15:0]           obs;
      logic [15:0]           thresh;
      logic [RATE_BITS-1:0]  minc;
      logic [RATE_BITS-1:0]  maxc;
      logic [COUNT_BITS-1:0] minp;
   } burst_type;

   typedef struct packed {
      logic [1:0]            channel;
      verdict_type           verdict;
      logic [TIME_BITS-1:0]  seq;
      logic [COUNT_BITS-1:0] count;
      logic [CAD_BITS-1:0]   cadence;
      logic [TIME_BITS-1:0]  duration;
      logic [CONF_BITS-1:0]  conf;
      logic [TIME_BITS-1:0]  now;
   } result_type;
endpackage
`default_nettype wire

### rtl/core/pceq_front.sv
// per channel comparator, burst tracking and end-of-burst detection
`default_nettype none
module pceq_front #(
   parameter int CHANNELS = 3,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write,
   input  wire logic [pceq_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [pceq_pkg::LEVEL_REG_BITS-1:0]    csr_data,
   input  wire logic                                   in_valid,
   input  wire logic [1:0]                             in_channel,
   input  wire logic [SAMPLE_BITS-1:0]                 in_sample,
   input  wire logic [pceq_pkg::TIME_BITS-1:0]         in_now,
   output logic                                        burst_valid,
   output pceq_pkg::burst_type                         burst,
   output logic                                        reject_valid,
   output logic [1:0]                                  reject_channel
);
   localparam logic [SAMPLE_BITS-1:0] SMAX = {SAMPLE_BITS{1'b1}};
   localparam int TB = pceq_pkg::TIME_BITS;
   localparam int CB = pceq_pkg::COUNT_BITS;

   logic [pceq_pkg::LEVEL_REG_BITS-1:0] lv_ff [CHANNELS];
   logic [pceq_pkg::CAD_REG_BITS-1:0]   cd_ff [CHANNELS];
   logic [CHANNELS-1:0] high_ff, act_ff;
   logic [TB-1:0] first_ff [CHANNELS];
   logic [TB-1:0] lrise_ff [CHANNELS];
   logic [TB-1:0] ledge_ff [CHANNELS];
   logic [CB-1:0] cnt_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] peak_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] trough_ff [CHANNELS];

   logic ok_ch;
   logic [1:0] ch;
   logic [pceq_pkg::LEVEL_REG_BITS-1:0] lv;
   logic [pceq_pkg::CAD_REG_BITS-1:0] cd;
   logic [11:0] on_l, off_l;
   logic [15:0] minp, gap;
   logic [19:0] minc, maxc;
   logic qual, rise, fall, high_n, act_n, close, few, take;
   logic [TB-1:0] first_n, lrise_n, ledge_n;
   logic [CB-1:0] cnt_n;
   logic [SAMPLE_BITS-1:0] peak_n, trough_n, smp;
   logic [TB-1:0] span;

   assign ch = in_channel;
   assign ok_ch = {30'd0, ch} < CHANNELS;
   assign smp = in_sample;

   always_comb begin
      lv = '0;
      cd = '0;
      high_n = 1'b0;
      act_n = 1'b0;
      first_n = '0;
      lrise_n = '0;
      ledge_n = '0;
      cnt_n = '0;
      peak_n = '0;
      trough_n = SMAX;
      for (int c = 0; c < CHANNELS; c++) begin
         if (ch == c[1:0]) begin
            lv = lv_ff[c];
            cd = cd_ff[c];
            high_n = high_ff[c];
            act_n = act_ff[c];
            first_n = first_ff[c];
            lrise_n = lrise_ff[c];
            ledge_n = ledge_ff[c];
            cnt_n = cnt_ff[c];
            peak_n = peak_ff[c];
            trough_n = trough_ff[c];
         end
      end
      on_l = lv[11:0];
      off_l = lv[23:12];
      minp = lv[39:24];
      gap = lv[55:40];
      minc = cd[19:0];
      maxc = cd[39:20];
      if (smp > peak_n) peak_n = smp;
      if (smp < trough_n) trough_n = smp;
      qual = on_l > off_l && off_l != 12'd0 && minc != 20'd0 && maxc >= minc
             && minp >= 16'd2 && gap != 16'd0;
      rise = qual && !high_n && {{(16-SAMPLE_BITS){1'b0}}, smp} >= {4'd0, on_l};
      fall = qual && high_n && {{(16-SAMPLE_BITS){1'b0}}, smp} <= {4'd0, off_l};
      if (rise) begin
         high_n = 1'b1;
         ledge_n = in_now;
         if (!act_n) begin
            act_n = 1'b1;
            first_n = in_now;
            lrise_n = in_now;
            cnt_n = 16'd1;
            peak_n = smp;
            trough_n = smp;
         end else begin
            lrise_n = in_now;
            if (cnt_n != {CB{1'b1}}) cnt_n = cnt_n + 16'd1;
         end
      end else if (fall) begin
         high_n = 1'b0;
         ledge_n = in_now;
      end
      close = qual && act_n && !high_n && (in_now - ledge_n) >= {16'd0, gap};
      span = lrise_n - first_n;
      few = cnt_n < 16'd2 || span == '0;
      take = in_valid && ok_ch && !csr_write && close;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            lv_ff[c] <= '0;
            cd_ff[c] <= '0;
            high_ff[c] <= 1'b0;
            act_ff[c] <= 1'b0;
            first_ff[c] <= '0;
            lrise_ff[c] <= '0;
            ledge_ff[c] <= '0;
            cnt_ff[c] <= '0;
            peak_ff[c] <= '0;
            trough_ff[c] <= SMAX;
         end
      end else if (csr_write) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if ({1'b0, csr_index} < 4'(pceq_pkg::NUM_REGS) && csr_index[2:1] == c[1:0]) begin
               if (csr_index[0]) cd_ff[c] <= csr_data[pceq_pkg::CAD_REG_BITS-1:0];
               else lv_ff[c] <= csr_data;
               act_ff[c] <= 1'b0;
               first_ff[c] <= '0;
               lrise_ff[c] <= '0;
               ledge_ff[c] <= '0;
               cnt_ff[c] <= '0;
               peak_ff[c] <= '0;
               trough_ff[c] <= SMAX;
            end
         end
      end else if (in_valid && ok_ch) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (ch == c[1:0]) begin
               high_ff[c] <= high_n;
               if (close) begin
                  act_ff[c] <= 1'b0;
                  first_ff[c] <= '0;
                  lrise_ff[c] <= '0;
                  ledge_ff[c] <= '0;
                  cnt_ff[c] <= '0;
                  peak_ff[c] <= '0;
                  trough_ff[c] <= SMAX;
               end else begin
                  act_ff[c] <= act_n;
                  first_ff[c] <= first_n;
                  lrise_ff[c] <= lrise_n;
                  ledge_ff[c] <= ledge_n;
                  cnt_ff[c] <= cnt_n;
                  peak_ff[c] <= peak_n;
                  trough_ff[c] <= trough_n;
               end
            end
         end
      end
      burst_valid <= !reset && take && !few;
      reject_valid <= !reset && take && few;
      reject_channel <= ch;
      burst.channel <= ch;
      burst.count <= cnt_n;
      burst.span <= span;
      burst.duration <= in_now - first_n;
      burst.now <= in_now;
      burst.obs <= (peak_n > trough_n) ? 16'(peak_n - trough_n) : 16'd0;
      burst.thresh <= {4'd0, on_l - off_l};
      burst.minc <= minc;
      burst.maxc <= maxc;
      burst.minp <= minp;
   end
endmodule
`default_nettype wire

### rtl/core/pceq_back.sv
// cadence check, cadence and confidence division, sequence numbering
`default_nettype none
module pceq_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  pceq_pkg::burst_type       burst,
   output logic                      busy,
   output logic                      done,
   output pceq_pkg::result_type      result,
   input  wire logic                 taken
);
   localparam int NB = pceq_pkg::DIV_NUM_BITS;
   localparam int TB = pceq_pkg::TIME_BITS;

   pceq_pkg::back_state_type state_ff, state_in;
   pceq_pkg::burst_type b_ff;
   logic [NB-1:0] num_ff, num_in;
   logic [52:0] lo_ff, hi_ff, lo_in, hi_in;
   logic [NB-1:0] quo_ff, quo_in;
   logic [TB:0] rem_ff, rem_in;
   logic [5:0] bit_ff, bit_in;
   logic [TB-1:0] seq_ff, seq_in;
   pceq_pkg::result_type res_ff, res_in;
   logic [TB:0] trial;
   logic [TB-1:0] divisor;

   assign busy = state_ff != pceq_pkg::BK_IDLE;
   assign done = state_ff == pceq_pkg::BK_DONE;
   assign result = res_ff;
   assign divisor = (state_ff == pceq_pkg::BK_DIV_CAD) ? b_ff.span : {16'd0, b_ff.thresh};
   assign trial = {rem_ff[TB-1:0], num_ff[NB-1]} - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pceq_pkg::BK_IDLE;
         seq_ff <= '0;
      end else begin
         state_ff <= state_in;
         seq_ff <= seq_in;
      end
      if (start && !busy) b_ff <= burst;
      num_ff <= num_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      num_in = num_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      seq_in = seq_ff;
      res_in = res_ff;
      unique case (state_ff)
         pceq_pkg::BK_IDLE: begin
            if (start) state_in = pceq_pkg::BK_MUL;
         end
         pceq_pkg::BK_MUL: begin
            num_in = NB'(b_ff.count - 16'd1) * NB'(pceq_pkg::MHZ_PER_HZ);
            lo_in = b_ff.minc * b_ff.span;
            hi_in = b_ff.maxc * b_ff.span;
            state_in = pceq_pkg::BK_CHECK;
         end
         pceq_pkg::BK_CHECK: begin
            res_in = '0;
            res_in.channel = b_ff.channel;
            if ({17'd0, num_ff} < lo_ff || {17'd0, num_ff} > hi_ff
                || b_ff.count < b_ff.minp) begin
               res_in.verdict = pceq_pkg::VERDICT_LIMIT;
               state_in = pceq_pkg::BK_DONE;
            end else begin
               res_in.verdict = pceq_pkg::VERDICT_QUALIFIED;
               res_in.seq = seq_ff + 32'd1;
               seq_in = seq_ff + 32'd1;
               res_in.count = b_ff.count;
               res_in.duration = b_ff.duration;
               res_in.now = b_ff.now;
               rem_in = '0;
               quo_in = '0;
               bit_in = 6'(NB);
               state_in = pceq_pkg::BK_DIV_CAD;
            end
         end
         pceq_pkg::BK_DIV_CAD, pceq_pkg::BK_DIV_CONF: begin
            if (bit_ff != 6'd0) begin
               num_in = {num_ff[NB-2:0], 1'b0};
               bit_in = bit_ff - 6'd1;
               if (!trial[TB]) begin
                  rem_in = trial;
                  quo_in = {quo_ff[NB-2:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[TB-1:0], num_ff[NB-1]};
                  quo_in = {quo_ff[NB-2:0], 1'b0};
               end
            end else if (state_ff == pceq_pkg::BK_DIV_CAD) begin
               res_in.cadence = (quo_ff > NB'(pceq_pkg::CAD_SAT)) ? pceq_pkg::CAD_SAT
                                : quo_ff[pceq_pkg::CAD_BITS-1:0];
               num_in = NB'({b_ff.obs, 10'd0});
               rem_in = '0;
               quo_in = '0;
               bit_in = 6'd26;
               num_in = {num_in[25:0], 10'd0};
               state_in = pceq_pkg::BK_DIV_CONF;
            end else begin
               res_in.conf = (quo_ff > NB'(pceq_pkg::CONF_ONE)) ? pceq_pkg::CONF_ONE
                             : quo_ff[pceq_pkg::CONF_BITS-1:0];
               state_in = pceq_pkg::BK_DONE;
            end
         end
         pceq_pkg::BK_DONE: begin
            if (taken) state_in = pceq_pkg::BK_IDLE;
         end
         default: state_in = pceq_pkg::BK_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### rtl/core/pulse_cadence_event_qualifier.sv
// top level: front tracker, burst queue, back calculator and output register
//
//  channel  | handshake     | payload
//  req_     | push / full   | channel, sample, now_ms
//  rsp_     | empty / pop   | verdict and burst figures
//  csr_     | write enable  | index, data
//
// a sample is registered in the front; a qualified burst then passes through the
// back's multiply, check and bit-serial division states (36 steps for cadence,
// 26 for confidence). full rises while a closed burst waits, the back is busy or
// the output register is held; rejected bursts need no back work.
`default_nettype none
module pulse_cadence_event_qualifier #(
   parameter int CHANNELS = 3,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   push,
   output logic                                        full,
   input  wire logic [1:0]                             req_channel,
   input  wire logic [SAMPLE_BITS-1:0]                 req_sample,
   input  wire logic [31:0]                            req_now_ms,
   output logic                                        empty,
   input  wire logic                                   pop,
   output logic [1:0]                                  rsp_event_channel,
   output logic [1:0]                                  rsp_verdict,
   output logic [31:0]                                 rsp_sequence_res,
   output logic [15:0]                                 rsp_pulse_count,
   output logic [23:0]                                 rsp_cadence_mhz,
   output logic [31:0]                                 rsp_duration_ms,
   output logic [10:0]                                 rsp_confidence_q10,
   output logic [31:0]                                 rsp_detected_at_ms,
   input  wire logic                                   csr_write,
   input  wire logic [pceq_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [pceq_pkg::LEVEL_REG_BITS-1:0]    csr_data
);
   logic bv, rv, back_busy, back_done, q_full_ff, out_full_ff, take_back;
   logic [1:0] rch;
   pceq_pkg::burst_type burst, q_ff;
   pceq_pkg::result_type bres, out_ff, rej_word;

   // one item in flight between front and back at a time
   assign full = q_full_ff || back_busy || out_full_ff || bv || rv;

   pceq_front #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .in_valid(push && !full), .in_channel(req_channel), .in_sample(req_sample),
      .in_now(req_now_ms), .burst_valid(bv), .burst, .reject_valid(rv),
      .reject_channel(rch)
   );

   pceq_back u_back (
      .clock, .reset, .start(q_full_ff && !back_busy), .burst(q_ff),
      .busy(back_busy), .done(back_done), .result(bres), .taken(take_back)
   );

   assign take_back = back_done && !out_full_ff;

   always_comb begin
      rej_word = '0;
      rej_word.channel = rch;
      rej_word.verdict = pceq_pkg::VERDICT_FEW_RISES;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_full_ff <= 1'b0;
         out_full_ff <= 1'b0;
      end else begin
         if (bv) q_full_ff <= 1'b1;
         else if (!back_busy) q_full_ff <= 1'b0;
         if (rv || take_back) out_full_ff <= 1'b1;
         else if (pop) out_full_ff <= 1'b0;
      end
      if (bv) q_ff <= burst;
      if (rv) begin
         out_ff <= rej_word;
      end else if (take_back) begin
         out_ff <= bres;
      end
   end

   assign empty = !out_full_ff;
   assign rsp_event_channel = out_ff.channel;
   assign rsp_verdict = out_ff.verdict;
   assign rsp_sequence_res = out_ff.seq;
   assign rsp_pulse_count = out_ff.count;
   assign rsp_cadence_mhz = out_ff.cadence;
   assign rsp_duration_ms = out_ff.duration;
   assign rsp_confidence_q10 = out_ff.conf;
   assign rsp_detected_at_ms = out_ff.now;
endmodule
`default_nettype wire

### rtl/core/pceq_checker.sv
// port-level checks of the qualifier
`default_nettype none
module pceq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic        full,
   input wire logic [1:0]  rsp_verdict,
   input wire logic [31:0] rsp_sequence_res,
   input wire logic [23:0] rsp_cadence_mhz
);
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_verdict <= pceq_pkg::VERDICT_FEW_RISES))
      else $error("bad verdict");
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_verdict != pceq_pkg::VERDICT_QUALIFIED)
      |-> (rsp_sequence_res == 32'd0 && rsp_cadence_mhz == 24'd0))
      else $error("rejected word carries figures");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_sequence_res)))
      else $error("waiting word changed");
   a_full_when_held: assert property (@(posedge clock) disable iff (reset)
      !empty |-> full)
      else $error("accepting with word waiting");
endmodule
bind pulse_cadence_event_qualifier pceq_checker u_pceq_checker (
   .clock, .reset, .empty, .pop, .full, .rsp_verdict, .rsp_sequence_res, .rsp_cadence_mhz
);
`default_nettype wire
